// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the box blur core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define BLR_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define BLR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/blr_pkg.sv
// ----------------------------------------------------------------------------
// blr_pkg
// Types, constants and helper functions of the 3x3 box blur core.
// ----------------------------------------------------------------------------
package blr_pkg;

  // Field widths
  localparam int CH_W     = 8;
  localparam int PIX_W    = 3 * CH_W;
  localparam int CFG_W_W  = 11;
  localparam int CFG_H_W  = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_D_W  = 13;

  // Accumulator and divider widths
  localparam int SUM_W    = 12;   // 9 * 255 fits
  localparam int CNT_W    = 4;    // 0..9 neighbors
  localparam int DIVX_W   = 13;   // 2*sum + count
  localparam int RECIP_W  = 18;
  localparam int RECIP_SH = 18;
  localparam int PROD_W   = DIVX_W + RECIP_W;

  // Defaults
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int RST_WIDTH      = 640;
  localparam int RST_HEIGHT     = 480;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } blr_cfg_reg_t;

  // Input item modes
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_ACC,
    S_MUL,
    S_OUT,
    S_DR1,
    S_DR2,
    S_DR3
  } blr_state_t;

  // Accumulator source
  typedef enum logic {
    SRC_WIN,
    SRC_STORE
  } blr_src_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       px_cap;
    logic       wr_en;
    logic       shift;
    logic       acc_clr;
    logic       acc_en;
    blr_src_t   acc_src;
    logic [1:0] acc_col;
    logic       acc_top;
    logic       acc_use;
    logic       mul_en;
    logic       out_load;
    logic       out_fend;
  } blr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } blr_sts_t;

  // ceil(2^18 / (2n)): exact floor division of 2*sum+n by 2n for n = 1..9
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] m;
    case (n)
      4'd1:    m = 18'd131072;
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd5:    m = 18'd26215;
      4'd6:    m = 18'd21846;
      4'd7:    m = 18'd18725;
      4'd8:    m = 18'd16384;
      4'd9:    m = 18'd14564;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/blr_pix_if.sv
// ----------------------------------------------------------------------------
// blr_pix_if
// Input item channel: mode and one RGB pixel.
// ----------------------------------------------------------------------------
interface blr_pix_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [blr_pkg::CH_W-1:0] in_red;
  logic [blr_pkg::CH_W-1:0] in_green;
  logic [blr_pkg::CH_W-1:0] in_blue;

  modport source (output valid, mode, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, mode, in_red, in_green, in_blue, output ready);
endinterface

// File: rtl/blr_res_if.sv
// ----------------------------------------------------------------------------
// blr_res_if
// Result item channel: blurred pixel and end-of-frame mark.
// ----------------------------------------------------------------------------
interface blr_res_if;
  logic                     valid;
  logic                     ready;
  logic [blr_pkg::CH_W-1:0] out_red;
  logic [blr_pkg::CH_W-1:0] out_green;
  logic [blr_pkg::CH_W-1:0] out_blue;
  logic                     frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

// File: rtl/blr_cfg_if.sv
// ----------------------------------------------------------------------------
// blr_cfg_if
// Configuration write channel: register index and data.
// ----------------------------------------------------------------------------
interface blr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [blr_pkg::CFG_IDX_W-1:0] index;
  logic [blr_pkg::CFG_D_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/box_blur_3x3_rgb_core.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_core
// 3x3 box blur over a raster RGB pixel stream with edge-aware averaging.
// ----------------------------------------------------------------------------
// Usage:
//   in_px  : valid/ready; mode 0 carries a pixel, mode 1 is a drain step.
//            Pixels go in raster order; once the frame's rows are in, one
//            drain item per pixel of the last row flushes it out.
//   out_px : valid/ready; blurred pixel, frame_end on the frame's last one.
//   cfg_wr : always ready; index 0 = frame width, index 1 = frame height.
//            Write only while the core is idle.
// Timing: items are handled one at a time, in_px.ready is high only when
//   the sequencer is idle. A pixel item yields at most two results, the
//   second one at a row end; a drain item yields one, and an item of the
//   wrong mode for the phase is ignored. The cost is set by the
//   accumulator, which sums one window column (or one line-store read)
//   per cycle, and by the registered reciprocal multiply.
// Reset: synchronous, active low; counters and window clear, frame size
//   returns to 640x480. The line stores are not cleared.
// Stall: a result sits in the output register until taken; the next result
//   waits in S_OUT meanwhile, and the core takes no items while it waits.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_core #(
  parameter int MAX_WIDTH  = blr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = blr_pkg::DEF_MAX_HEIGHT
) (
  input logic       clk,
  input logic       rst_n,
  blr_pix_if.sink   in_px,
  blr_res_if.source out_px,
  blr_cfg_if.sink   cfg_wr
);

  import blr_pkg::*;

  localparam int IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  blr_cmd_t      cmd;
  blr_sts_t      sts;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;

  // Sequencer
  blr_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .IW(IW)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .pix     (in_px),
    .cfg     (cfg_wr),
    .cmd     (cmd),
    .sts     (sts),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr)
  );

  // Line stores, window and arithmetic
  blr_dp #(.MAX_WIDTH(MAX_WIDTH), .IW(IW)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .in_red   (in_px.in_red),
    .in_green (in_px.in_green),
    .in_blue  (in_px.in_blue),
    .res      (out_px)
  );

endmodule

// File: rtl/blr_ram.sv
// ----------------------------------------------------------------------------
// blr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module blr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/blr_dp.sv
// ----------------------------------------------------------------------------
// blr_dp
// Datapath: line stores, 3x3 window, neighbor accumulator, reciprocal
// divider and output register.
// ----------------------------------------------------------------------------
module blr_dp #(
  parameter int MAX_WIDTH = blr_pkg::DEF_MAX_WIDTH,
  parameter int IW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  blr_pkg::blr_cmd_t        cmd,
  output blr_pkg::blr_sts_t        sts,
  input  logic [IW-1:0]            rd_addr,
  input  logic [IW-1:0]            wr_addr,
  input  logic [blr_pkg::CH_W-1:0] in_red,
  input  logic [blr_pkg::CH_W-1:0] in_green,
  input  logic [blr_pkg::CH_W-1:0] in_blue,
  blr_res_if.source                res
);

  import blr_pkg::*;

  logic [PIX_W-1:0]  px_r;
  logic [PIX_W-1:0]  upper_q;
  logic [PIX_W-1:0]  lower_q;
  logic [PIX_W-1:0]  win_r [3][3];
  logic [SUM_W-1:0]  sum_r [3];
  logic [SUM_W-1:0]  sum_nxt [3];
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [PROD_W-1:0] prod_r [3];
  logic [CH_W-1:0]   quo [3];
  logic [CH_W-1:0]   res_ch_r [3];
  logic              fend_r;
  logic              out_valid_r;

  // Line stores: upper holds row r-2, lower holds row r-1
  blr_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH), .AW(IW)) u_upper (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (lower_q),
    .rd_addr (rd_addr),
    .rd_data (upper_q)
  );

  blr_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH), .AW(IW)) u_lower (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (px_r),
    .rd_addr (rd_addr),
    .rd_data (lower_q)
  );

  // Incoming pixel capture
  always_ff @(posedge clk) begin
    if (cmd.px_cap) begin
      px_r <= {in_red, in_green, in_blue};
    end
  end

  // 3x3 window, column 2 is the newest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (cmd.shift) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= upper_q;
      win_r[1][2] <= lower_q;
      win_r[2][2] <= px_r;
    end
  end

  // Accumulator: up to three pixels a cycle, from a window column or the stores
  always_comb begin
    logic [PIX_W-1:0] a0, a1, a2;
    logic             e0, e1, e2;
    if (cmd.acc_src == SRC_WIN) begin
      a0 = win_r[0][cmd.acc_col];
      a1 = win_r[1][cmd.acc_col];
      a2 = win_r[2][cmd.acc_col];
      e0 = cmd.acc_top;
      e1 = 1'b1;
      e2 = 1'b1;
    end else begin
      a0 = upper_q;
      a1 = lower_q;
      a2 = '0;
      e0 = cmd.acc_top && cmd.acc_use;
      e1 = cmd.acc_use;
      e2 = 1'b0;
    end
    for (int k = 0; k < 3; k++) begin
      sum_nxt[k] = sum_r[k]
                 + (e0 ? SUM_W'(a0[CH_W*(2-k) +: CH_W]) : '0)
                 + (e1 ? SUM_W'(a1[CH_W*(2-k) +: CH_W]) : '0)
                 + (e2 ? SUM_W'(a2[CH_W*(2-k) +: CH_W]) : '0);
    end
    cnt_nxt = cnt_r + CNT_W'(e0) + CNT_W'(e1) + CNT_W'(e2);
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      for (int k = 0; k < 3; k++) begin
        sum_r[k] <= '0;
      end
      cnt_r <= '0;
    end else if (cmd.acc_en) begin
      for (int k = 0; k < 3; k++) begin
        sum_r[k] <= sum_nxt[k];
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Rounded mean: (2*sum + n) * ceil(2^18 / 2n) >> 18
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= PROD_W'({sum_r[k], 1'b0} + DIVX_W'(cnt_r)) * PROD_W'(recip(cnt_r));
      end
    end
  end

  // Saturate to channel range
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      quo[k] = (prod_r[k][PROD_W-1:RECIP_SH] > DIVX_W'(255)) ? '1
             : prod_r[k][RECIP_SH +: CH_W];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int k = 0; k < 3; k++) begin
        res_ch_r[k] <= quo[k];
      end
      fend_r <= cmd.out_fend;
    end
  end

  assign res.valid     = out_valid_r;
  assign res.out_red   = res_ch_r[0];
  assign res.out_green = res_ch_r[1];
  assign res.out_blue  = res_ch_r[2];
  assign res.frame_end = fend_r;
  assign sts.out_free  = !out_valid_r || res.ready;

endmodule

// File: rtl/blr_ctrl.sv
// ----------------------------------------------------------------------------
// blr_ctrl
// Controller: configuration registers, frame counters and the sequencer
// that steers the datapath for pixel and drain items.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module blr_ctrl #(
  parameter int MAX_WIDTH  = blr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = blr_pkg::DEF_MAX_HEIGHT,
  parameter int IW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  blr_pix_if.sink           pix,
  blr_cfg_if.sink           cfg,
  output blr_pkg::blr_cmd_t cmd,
  input  blr_pkg::blr_sts_t sts,
  output logic [IW-1:0]     rd_addr,
  output logic [IW-1:0]     wr_addr
);

  import blr_pkg::*;

  localparam int WCW = ($clog2(MAX_WIDTH + 1) > CFG_W_W) ? $clog2(MAX_WIDTH + 1) : CFG_W_W;
  localparam int HCW = ($clog2(MAX_HEIGHT + 1) > CFG_H_W) ? $clog2(MAX_HEIGHT + 1) : CFG_H_W;

  blr_state_t       state_r, state_nxt;
  logic [CFG_W_W-1:0] frame_width_r;
  logic [CFG_H_W-1:0] frame_height_r;
  logic [HCW-1:0]   row_r, row_nxt;
  logic [IW-1:0]    col_r, col_nxt;
  logic [IW-1:0]    drn_r, drn_nxt;
  logic [IW-1:0]    addr_r, addr_nxt;
  logic             emit_a_r, emit_a_nxt;
  logic             pend_b_r, pend_b_nxt;
  logic [1:0]       col_j_r, col_j_nxt;
  logic [1:0]       lo_b_r, lo_b_nxt;
  logic             top_r, top_nxt;
  logic             fend_r, fend_nxt;
  logic             k0_r, k0_nxt;
  logic             k2_r, k2_nxt;

  logic [WCW-1:0]   fw_ext, eff_w, c_ext, d_ext;
  logic [HCW-1:0]   fh_ext, eff_h;
  logic             px_phase, accept, row_end, d_last, d_hi_ok;

  // Clamp configured frame size
  always_comb begin
    fw_ext = WCW'(frame_width_r);
    fh_ext = HCW'(frame_height_r);
    if (fw_ext == '0) begin
      eff_w = WCW'(1);
    end else if (fw_ext > WCW'(MAX_WIDTH)) begin
      eff_w = WCW'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end
    if (fh_ext == '0) begin
      eff_h = HCW'(1);
    end else if (fh_ext > HCW'(MAX_HEIGHT)) begin
      eff_h = HCW'(MAX_HEIGHT);
    end else begin
      eff_h = fh_ext;
    end
  end

  // Phase and position flags
  assign px_phase = row_r < eff_h;
  assign accept   = pix.valid && pix.ready;
  assign c_ext    = WCW'(col_r);
  assign d_ext    = WCW'(drn_r);
  assign row_end  = (c_ext + WCW'(1)) >= eff_w;
  assign d_last   = (d_ext + WCW'(1)) >= eff_w;
  assign d_hi_ok  = (d_ext + WCW'(1)) < WCW'(MAX_WIDTH);

  // Configuration writes, always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CFG_W_W'(RST_WIDTH);
      frame_height_r <= CFG_H_W'(RST_HEIGHT);
    end else if (cfg.valid) begin
      unique case (blr_cfg_reg_t'(cfg.index))
        REG_FRAME_WIDTH:  frame_width_r  <= cfg.data[CFG_W_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg.data[CFG_H_W-1:0];
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && px_phase && pix.mode == MODE_PIXEL) begin
          state_nxt = S_SHIFT;
        end else if (accept && !px_phase && pix.mode == MODE_DRAIN) begin
          state_nxt = S_DR1;
        end
      end
      S_SHIFT: state_nxt = (emit_a_r || pend_b_r) ? S_ACC : S_IDLE;
      S_ACC:   state_nxt = (col_j_r == 2'd2) ? S_MUL : S_ACC;
      S_MUL:   state_nxt = S_OUT;
      S_OUT: begin
        if (sts.out_free) begin
          state_nxt = pend_b_r ? S_ACC : S_IDLE;
        end
      end
      S_DR1:   state_nxt = S_DR2;
      S_DR2:   state_nxt = S_DR3;
      S_DR3:   state_nxt = S_MUL;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd         = '0;
    cmd.acc_src = SRC_WIN;
    cmd.acc_col = col_j_r;
    cmd.acc_top = top_r;
    cmd.out_fend = fend_r;
    pix.ready   = 1'b0;
    rd_addr     = addr_r;
    wr_addr     = addr_r;
    unique case (state_r)
      S_IDLE: begin
        pix.ready   = 1'b1;
        cmd.px_cap  = accept;
        cmd.acc_clr = accept && !px_phase;
        rd_addr     = px_phase ? col_r : (drn_r - 1'b1);
      end
      S_SHIFT: begin
        cmd.wr_en   = 1'b1;
        cmd.shift   = 1'b1;
        cmd.acc_clr = 1'b1;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
      end
      S_OUT: begin
        cmd.out_load = sts.out_free;
        cmd.acc_clr  = sts.out_free && pend_b_r;
      end
      S_DR1: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_src = SRC_STORE;
        cmd.acc_use = k0_r;
        rd_addr     = addr_r;
      end
      S_DR2: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_src = SRC_STORE;
        cmd.acc_use = 1'b1;
        rd_addr     = addr_r + 1'b1;
      end
      S_DR3: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_src = SRC_STORE;
        cmd.acc_use = k2_r;
      end
      default: begin
        pix.ready = 1'b0;
      end
    endcase
  end

  // Counters and per-item flags
  always_comb begin
    row_nxt    = row_r;
    col_nxt    = col_r;
    drn_nxt    = drn_r;
    addr_nxt   = addr_r;
    emit_a_nxt = emit_a_r;
    pend_b_nxt = pend_b_r;
    col_j_nxt  = col_j_r;
    lo_b_nxt   = lo_b_r;
    top_nxt    = top_r;
    fend_nxt   = fend_r;
    k0_nxt     = k0_r;
    k2_nxt     = k2_r;
    if (state_r == S_IDLE && accept && px_phase && pix.mode == MODE_PIXEL) begin
      // new pixel: (r-1,c-1) and, at row end, (r-1,last)
      addr_nxt   = col_r;
      emit_a_nxt = (row_r != '0) && (col_r != '0);
      pend_b_nxt = row_end && (row_r != '0);
      col_j_nxt  = (c_ext >= WCW'(2)) ? 2'd0 : 2'd1;
      lo_b_nxt   = (col_r != '0) ? 2'd1 : 2'd2;
      top_nxt    = row_r >= HCW'(2);
      fend_nxt   = 1'b0;
      if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
        drn_nxt = '0;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end else if (state_r == S_IDLE && accept && !px_phase && pix.mode == MODE_DRAIN) begin
      // drain step: one pixel of the last row from the line stores
      addr_nxt = drn_r;
      k0_nxt   = drn_r != '0;
      k2_nxt   = !d_last && d_hi_ok;
      top_nxt  = row_r >= HCW'(2);
      fend_nxt = d_last;
      if (d_last) begin
        row_nxt = '0;
        col_nxt = '0;
        drn_nxt = '0;
      end else begin
        drn_nxt = drn_r + 1'b1;
      end
    end else if (state_r == S_SHIFT) begin
      if (emit_a_r) begin
        emit_a_nxt = 1'b0;
      end else if (pend_b_r) begin
        col_j_nxt  = lo_b_r;
        pend_b_nxt = 1'b0;
      end
    end else if (state_r == S_ACC) begin
      col_j_nxt = col_j_r + 1'b1;
    end else if (state_r == S_OUT && sts.out_free && pend_b_r) begin
      col_j_nxt  = lo_b_r;
      pend_b_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      row_r    <= '0;
      col_r    <= '0;
      drn_r    <= '0;
      emit_a_r <= 1'b0;
      pend_b_r <= 1'b0;
      fend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      drn_r    <= drn_nxt;
      emit_a_r <= emit_a_nxt;
      pend_b_r <= pend_b_nxt;
      fend_r   <= fend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    col_j_r <= col_j_nxt;
    lo_b_r  <= lo_b_nxt;
    top_r   <= top_nxt;
    k0_r    <= k0_nxt;
    k2_r    <= k2_nxt;
  end

  // A pending row-end result keeps the sequencer busy
  `BLR_ASSERT_IMPL(a_pend_busy, clk, rst_n, pend_b_r, state_r != S_IDLE, "row-end result lost")
  // Results only go into a free output register
  `BLR_ASSERT_IMPL(a_load_free, clk, rst_n, cmd.out_load, sts.out_free, "output overwritten")
  // A finished result waits while the receiver stalls
  `BLR_ASSERT_NEXT(a_out_wait, clk, rst_n, state_r == S_OUT && !sts.out_free,
                   state_r == S_OUT, "stalled result dropped")

endmodule
